### rtl/ptd_pkg.sv
// Package for the periodic task dispatcher.
// Holds field widths, action and result codes, and the shared unit request type.
// No dependencies.
package ptd_pkg;

    localparam int TIME_W       = 32;
    localparam int ACTION_W     = 2;
    localparam int TIDX_W       = 3;
    localparam int KIND_W       = 3;
    localparam int SLOT_W       = 3;
    localparam int DEF_TASKS    = 8;
    localparam int RESULT_LIMIT = 8;
    localparam int RES_CNT_W    = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_INIT   = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_REPORT = 2'd3
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 3'd0,
        KIND_INIT   = 3'd1,
        KIND_DISP   = 3'd2,
        KIND_NONE   = 3'd3,
        KIND_REPORT = 3'd4
    } t_kind;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [TIME_W-1:0]   a;
        logic [TIME_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic due_we;
        logic per_we;
    } t_tab_we;

endpackage

### rtl/ptd_alu.sv
// Shared 32-bit add and subtract unit with a registered result.
// Depends on ptd_pkg for the request type.
module ptd_alu (
    input  logic                       i_clk,
    input  ptd_pkg::t_alu_req          i_req,
    output logic [ptd_pkg::TIME_W-1:0] o_res
);
    import ptd_pkg::*;

    logic [TIME_W-1:0] r_res;

    always_ff @(posedge i_clk) begin
        if (i_req.op == ALU_SUB) begin
            r_res <= i_req.a - i_req.b;
        end else begin
            r_res <= i_req.a + i_req.b;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/ptd_table.sv
// Task table memory: due times and periods, one write port, one registered read.
// Depends on ptd_pkg for widths and the write enable type.
module ptd_table #(
    parameter int DEPTH = ptd_pkg::DEF_TASKS,
    parameter int AW    = 3
) (
    input  logic                       i_clk,
    input  ptd_pkg::t_tab_we           i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [ptd_pkg::TIME_W-1:0] i_due_wdata,
    input  logic [ptd_pkg::TIME_W-1:0] i_per_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [ptd_pkg::TIME_W-1:0] o_due,
    output logic [ptd_pkg::TIME_W-1:0] o_per
);
    import ptd_pkg::*;

    logic [TIME_W-1:0] r_due_mem [DEPTH];
    logic [TIME_W-1:0] r_per_mem [DEPTH];
    logic [TIME_W-1:0] r_due_rd;
    logic [TIME_W-1:0] r_per_rd;

    always_ff @(posedge i_clk) begin
        if (i_we.due_we) begin
            r_due_mem[i_waddr] <= i_due_wdata;
        end
        if (i_we.per_we) begin
            r_per_mem[i_waddr] <= i_per_wdata;
        end
        r_due_rd <= r_due_mem[i_raddr];
        r_per_rd <= r_per_mem[i_raddr];
    end

    assign o_due = r_due_rd;
    assign o_per = r_per_rd;

endmodule

### rtl/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher: request latch, sequencer and result port.
// Depends on ptd_pkg, ptd_alu and ptd_table.
//
//  channel   direction  handshake              payload
//  request   in         start high, busy low   i_action i_now_ms i_task_period i_task_index i_task_ok
//  result    out        o_strobe, one cycle    o_kind o_slot o_accepted o_last
//
// Add and report answer from S_ADD and S_REP; init walks the entries in turn, then answers.
// A tick scans the entries in turn: inactive ones are skipped, active ones pass S_CMP and S_ADV,
// dispatched ones also S_CHK, S_FIX and maybe S_WRP; the shared adder and table read port set this.
// Reset is synchronous and active low; the table needs no clearing pass.
// Results cannot be stalled; busy stays high until the final result is driven.
module periodic_task_dispatcher #(
    parameter int MAX_TASKS = ptd_pkg::DEF_TASKS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ptd_pkg::ACTION_W-1:0] i_action,
    input  logic [ptd_pkg::TIME_W-1:0]   i_now_ms,
    input  logic [ptd_pkg::TIME_W-1:0]   i_task_period,
    input  logic [ptd_pkg::TIDX_W-1:0]   i_task_index,
    input  logic                         i_task_ok,
    output logic                         o_strobe,
    output logic [ptd_pkg::KIND_W-1:0]   o_kind,
    output logic [ptd_pkg::SLOT_W-1:0]   o_slot,
    output logic                         o_accepted,
    output logic                         o_last
);
    import ptd_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);
    localparam logic [RES_CNT_W-1:0] RES_MAX = RES_CNT_W'(RESULT_LIMIT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_INIT,
        S_REP,
        S_SCAN,
        S_CMP,
        S_ADV,
        S_CHK,
        S_FIX,
        S_WRP,
        S_FIN
    } t_state;

    t_state                r_state;
    logic [TIME_W-1:0]     r_now;
    logic [TIME_W-1:0]     r_period;
    logic [TIDX_W-1:0]     r_tidx;
    logic                  r_ok;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic [MAX_TASKS-1:0]  r_active;
    logic [TIME_W-1:0]     r_ndue;
    logic                  r_pend;
    logic [SLOT_W-1:0]     r_pslot;
    logic [RES_CNT_W-1:0]  r_n;
    logic                  r_strobe;
    t_kind                 r_kind;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_accepted;
    logic                  r_last;

    t_alu_req              alu_req;
    logic [TIME_W-1:0]     alu_res;
    t_tab_we               tab_we;
    logic [IW-1:0]         tab_waddr;
    logic [TIME_W-1:0]     tab_due_wdata;
    logic [TIME_W-1:0]     rd_due;
    logic [TIME_W-1:0]     rd_per;
    logic [IW-1:0]         cur;
    logic                  scan_done;
    logic                  rep_hit;
    logic                  disp;

    assign cur       = r_idx[IW-1:0];
    assign scan_done = (r_idx >= r_count) || (r_n == RES_MAX);
    assign rep_hit   = !r_ok && (8'(r_tidx) < 8'(r_count));
    assign disp      = ((r_state == S_FIX) && alu_res[TIME_W-1]) || (r_state == S_WRP);

    ptd_alu u_alu (
        .i_clk (i_clk),
        .i_req (alu_req),
        .o_res (alu_res)
    );

    ptd_table #(
        .DEPTH (MAX_TASKS),
        .AW    (IW)
    ) u_table (
        .i_clk       (i_clk),
        .i_we        (tab_we),
        .i_waddr     (tab_waddr),
        .i_due_wdata (tab_due_wdata),
        .i_per_wdata (r_period),
        .i_raddr     (cur),
        .o_due       (rd_due),
        .o_per       (rd_per)
    );

    always_comb begin
        alu_req       = '{op: ALU_SUB, a: r_now, b: rd_due};
        tab_we        = '{due_we: 1'b0, per_we: 1'b0};
        tab_waddr     = cur;
        tab_due_wdata = r_now;
        case (r_state)
            S_ADD: begin
                tab_waddr     = r_count[IW-1:0];
                tab_due_wdata = '0;
                if (r_count < MAX_CNT) begin
                    tab_we = '{due_we: 1'b1, per_we: 1'b1};
                end
            end
            S_INIT: begin
                if (!scan_done && r_active[cur]) begin
                    tab_we.due_we = 1'b1;
                end
            end
            S_ADV: begin
                alu_req = '{op: ALU_ADD, a: rd_due, b: rd_per};
            end
            S_CHK: begin
                alu_req = '{op: ALU_SUB, a: r_now, b: alu_res};
            end
            S_FIX: begin
                alu_req       = '{op: ALU_ADD, a: r_now, b: rd_per};
                tab_due_wdata = r_ndue;
                tab_we.due_we = alu_res[TIME_W-1];
            end
            S_WRP: begin
                tab_due_wdata = alu_res;
                tab_we.due_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_active <= '0;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
            r_n      <= '0;
            r_idx    <= '0;
        end else begin
            r_strobe   <= 1'b0;
            r_accepted <= 1'b0;
            r_last     <= 1'b1;
            r_slot     <= '0;
            if (disp) begin
                if (r_pend) begin
                    r_strobe <= 1'b1;
                    r_kind   <= KIND_DISP;
                    r_slot   <= r_pslot;
                    r_last   <= 1'b0;
                end
                r_pend  <= 1'b1;
                r_pslot <= SLOT_W'(r_idx);
                r_n     <= r_n + 1'b1;
                r_idx   <= r_idx + 1'b1;
                r_state <= S_SCAN;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_now    <= i_now_ms;
                        r_period <= i_task_period;
                        r_tidx   <= i_task_index;
                        r_ok     <= i_task_ok;
                        r_idx    <= '0;
                        r_n      <= '0;
                        r_pend   <= 1'b0;
                        case (t_action'(i_action))
                            ACT_ADD:    r_state <= S_ADD;
                            ACT_INIT:   r_state <= S_INIT;
                            ACT_TICK:   r_state <= S_SCAN;
                            ACT_REPORT: r_state <= S_REP;
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ADD: begin
                    r_strobe <= 1'b1;
                    r_kind   <= KIND_ADD;
                    if (r_count < MAX_CNT) begin
                        r_active[r_count[IW-1:0]] <= 1'b1;
                        r_slot     <= SLOT_W'(r_count);
                        r_accepted <= 1'b1;
                        r_count    <= r_count + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_INIT: begin
                    if (scan_done) begin
                        r_strobe <= 1'b1;
                        r_kind   <= KIND_INIT;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_REP: begin
                    if (rep_hit) begin
                        r_active[IW'(r_tidx)] <= 1'b0;
                    end
                    r_strobe <= 1'b1;
                    r_kind   <= KIND_REPORT;
                    r_slot   <= SLOT_W'(r_tidx);
                    r_state  <= S_IDLE;
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_state <= S_FIN;
                    end else if (!r_active[cur]) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_ADV;
                end
                S_ADV: begin
                    if (alu_res[TIME_W-1]) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_ndue  <= alu_res;
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    if (!alu_res[TIME_W-1]) begin
                        r_state <= S_WRP;
                    end
                end
                S_WRP: begin
                end
                S_FIN: begin
                    r_strobe <= 1'b1;
                    if (r_pend) begin
                        r_kind <= KIND_DISP;
                        r_slot <= r_pslot;
                    end else begin
                        r_kind <= KIND_NONE;
                    end
                    r_pend  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_kind     = r_kind;
    assign o_slot     = r_slot;
    assign o_accepted = r_accepted;
    assign o_last     = r_last;

    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind != KIND_DISP)) |-> o_last)
        else $error("single result without last flag");

    a_accept_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_accepted) |-> (o_kind == KIND_ADD))
        else $error("accepted flag on a result that is not an add answer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= MAX_CNT) && (r_n <= RES_MAX))
        else $error("entry or result count beyond its limit");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

endmodule
